/* sv/tile_map_ray_march_top_macros.svh */
// Assertion helpers shared by the ray march RTL.
`ifndef TILE_MAP_RAY_MARCH_TOP_MACROS_SVH
`define TILE_MAP_RAY_MARCH_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TMRM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tmrm assertion failed");
`define TMRM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmrm assertion failed");
`else
`define TMRM_ASSERT(lbl, prop)
`define TMRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/tmrm_pkg.sv */
package tmrm_pkg;

	localparam int MAP_ROWS_DEF = 16;
	localparam int MAP_COLS = 16;
	localparam int ROW_BITS_W = 16;
	localparam int MAP_COLS_EFF = (MAP_COLS < ROW_BITS_W) ? MAP_COLS : ROW_BITS_W;

	localparam int LEN_W = 9;
	localparam int HGT_W = 11;
	localparam int POS_W = 14;
	localparam int ANG_W = 10;
	localparam int SCR_W = 12;
	localparam int TSH_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [LEN_W-1:0] STEP_LEN = 9'd3;
	localparam logic [LEN_W-1:0] MAX_LEN = 9'd501;
	localparam int START_OFF_Q4 = 128;
	localparam int DEN_OFFSET = 10000;

	localparam logic [TSH_W-1:0] TILE_SHIFT_RST = 3'd5;
	localparam logic [SCR_W-1:0] SCREEN_H_RST = 12'd480;

	// angles in half degrees
	localparam logic [10:0] ANG_QUAD = 11'd180;
	localparam logic [10:0] ANG_HALF = 11'd360;
	localparam logic [10:0] ANG_3QUAD = 11'd540;
	localparam logic [10:0] ANG_FULL = 11'd720;

	localparam int SIN_ENTRIES = 181;
	localparam int SIN_W = 15;
	localparam int TRIG_W = 16;
	localparam int SERIES_TERMS = 12;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] SERIES_DEN [1:SERIES_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	typedef enum logic {
		CMD_ROW_WRITE = 1'b0,
		CMD_CAST      = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_SHIFT    = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} hgt_stat_t;

	// Q1.14 quarter-wave sine, evaluated once at elaboration by a Q30 Taylor series
	function automatic logic [SIN_ENTRIES*SIN_W-1:0] build_sin_rom();
		logic [SIN_ENTRIES*SIN_W-1:0] rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] rnd;
		rom = '0;
		for (int k = 0; k < SIN_ENTRIES; k++) begin
			x = (64'(k) * PI_Q30 + 64'd180) / 64'd360;
			x2 = (x * x) >> 30;
			term = x;
			sum = $signed(x);
			for (int n = 1; n <= SERIES_TERMS; n++) begin
				term = (term * x2) / SERIES_DEN[n];
				term = term >> 30;
				if (n % 2 == 1)
					sum = sum - $signed(term);
				else
					sum = sum + $signed(term);
			end
			if (sum < 0)
				sum = 0;
			rnd = ($unsigned(sum) + 64'd32768) >> 16;
			rom[k*SIN_W +: SIN_W] = rnd[SIN_W-1:0];
		end
		return rom;
	endfunction

	localparam logic [SIN_ENTRIES*SIN_W-1:0] SIN_ROM = build_sin_rom();

	// sine of an angle in half degrees, input below twice a full turn
	function automatic logic signed [TRIG_W-1:0] sin_hd(input logic [10:0] a);
		logic [10:0] r;
		logic [7:0] idx;
		logic neg;
		logic [SIN_W-1:0] mag;
		r = (a >= ANG_FULL) ? a - ANG_FULL : a;
		if (r <= ANG_QUAD) begin
			idx = r[7:0];
			neg = 1'b0;
		end else if (r <= ANG_HALF) begin
			idx = 8'(ANG_HALF - r);
			neg = 1'b0;
		end else if (r <= ANG_3QUAD) begin
			idx = 8'(r - ANG_HALF);
			neg = 1'b1;
		end else begin
			idx = 8'(ANG_FULL - r);
			neg = 1'b1;
		end
		mag = SIN_ROM[32'(idx)*SIN_W +: SIN_W];
		return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

endpackage

/* sv/tmrm_map_mem.sv */
module tmrm_map_mem
	import tmrm_pkg::*;
#(
	parameter int ROWS = MAP_ROWS_DEF,
	parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [ROW_W-1:0]      wr_addr,
	input  logic [ROW_BITS_W-1:0] wr_data,
	input  logic [ROW_W-1:0]      rd_addr,
	output logic [ROW_BITS_W-1:0] rd_data
);

	logic [ROW_BITS_W-1:0] mem [ROWS];
	logic [ROWS-1:0] valid_q;
	logic [ROW_BITS_W-1:0] rd_data_q;
	logic rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
		rd_valid_q <= valid_q[rd_addr];
	end

	// rows never written read as open floor
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

/* sv/tmrm_height.sv */
module tmrm_height
	import tmrm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [LEN_W-1:0] len,
	input  logic [HGT_W-1:0] hh,
	output hgt_stat_t        stat,
	output logic [HGT_W-1:0] height
);

	typedef enum logic [2:0] {
		H_IDLE, H_SQ, H_PROD, H_SQT, H_MULT, H_CMP, H_DONE
	} hstate_t;

	hstate_t state_q;
	logic [LEN_W-1:0] len_q;
	logic [HGT_W-1:0] hh_q;
	logic [2*HGT_W-1:0] hh2_q;
	logic [2*LEN_W-1:0] len2_q;
	logic [2*HGT_W+2*LEN_W-1:0] lhs_q;
	logic [2*LEN_W-1:0] den_q;
	logic [2*HGT_W-1:0] sq_q;
	logic [2*HGT_W+2*LEN_W-1:0] prod_q;
	logic [HGT_W-1:0] m_q;
	logic [3:0] bit_q;
	logic [HGT_W-1:0] trial;

	assign trial = m_q | (HGT_W'(1) << bit_q);

	// largest m with m*m*(L*L+10000) <= hh*hh*L*L, settled one bit per pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			m_q <= '0;
			bit_q <= '0;
		end else if (start) begin
			len_q <= len;
			hh_q <= hh;
			state_q <= H_SQ;
		end else begin
			unique case (state_q)
				H_IDLE, H_DONE: begin
				end
				H_SQ: begin
					hh2_q <= hh_q * hh_q;
					len2_q <= len_q * len_q;
					state_q <= H_PROD;
				end
				H_PROD: begin
					lhs_q <= hh2_q * len2_q;
					den_q <= len2_q + (2*LEN_W)'(DEN_OFFSET);
					m_q <= '0;
					bit_q <= 4'(HGT_W - 1);
					state_q <= H_SQT;
				end
				H_SQT: begin
					sq_q <= trial * trial;
					state_q <= H_MULT;
				end
				H_MULT: begin
					prod_q <= sq_q * den_q;
					state_q <= H_CMP;
				end
				H_CMP: begin
					if (prod_q <= lhs_q)
						m_q <= trial;
					if (bit_q == '0) begin
						state_q <= H_DONE;
					end else begin
						bit_q <= bit_q - 4'd1;
						state_q <= H_SQT;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != H_IDLE) && (state_q != H_DONE);
	assign stat.done = (state_q == H_DONE);
	assign height = m_q;

endmodule

/* sv/tile_map_ray_march_top.sv */
// Tile-map ray marcher. Row-write beats (command 0) load one row of the wall map into
// a one-port-read map memory; they give no result. A cast beat (command 1) marches a
// ray from pos+8 px in 3 px steps until a wall cell or length 501, probing the map
// memory once per cycle with the next probe read issued while the previous one is
// checked, then runs an 11-bit bit-serial search for the band height (per bit:
// square, scale, compare). A cast of 1 to 167 probes passes through the setup states
// (S_INIT, S_LOAD), the march and the height search before its result beat. The input
// stalls for that time, and longer while an earlier result still waits in the output
// register. It then reopens while the result waits there. The map reads as empty
// after reset. Configuration writes are taken in any cycle; write them only while no
// cast is in flight.
`include "tile_map_ray_march_top_macros.svh"

module tile_map_ray_march_top
	import tmrm_pkg::*;
#(
	parameter int MAP_ROWS = MAP_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic [3:0]            row_index,
	input  logic [ROW_BITS_W-1:0] row_bits,
	input  logic [POS_W-1:0]      pos_x,
	input  logic [POS_W-1:0]      pos_y,
	input  logic [ANG_W-1:0]      angle,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LEN_W-1:0]      ray_length,
	output logic                  wall_hit,
	output logic [HGT_W-1:0]      half_height,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SCR_W-1:0]      cfg_data
);

	localparam int ROW_W = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
	localparam int PX_W = 26;
	localparam int DSTEP_W = 18;
	localparam int SCALE_SH = 10;

	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_LOAD, S_MARCH, S_HGT
	} state_t;

	state_t state_q;
	logic [TSH_W-1:0] tile_shift_q;
	logic [SCR_W-1:0] screen_h_q;
	logic [POS_W-1:0] pos_x_q, pos_y_q;
	logic [ANG_W-1:0] ang_q;
	logic signed [DSTEP_W-1:0] dc3_q, ds3_q;
	logic signed [PX_W-1:0] px_q, py_q;
	logic [LEN_W-1:0] len_q;

	logic vld_s1, in_map_s1;
	logic [3:0] col_s1;
	logic [LEN_W-1:0] len_s1;

	logic [LEN_W-1:0] fin_len_q;
	logic fin_hit_q;

	logic out_valid_q, wall_hit_q;
	logic [LEN_W-1:0] ray_length_q;
	logic [HGT_W-1:0] half_height_q;

	logic accept, wr_en, finish, wall, hgt_start, out_load;
	logic signed [TRIG_W-1:0] cos_c, sin_c;
	logic signed [DSTEP_W-1:0] dc3_c, ds3_c;
	logic [14:0] sxi, syi;
	logic [10:0] col_c, row_c;
	logic in_map_c;
	logic [ROW_BITS_W-1:0] rd_data;
	hgt_stat_t hstat;
	logic [HGT_W-1:0] height;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign wr_en = accept && (command == CMD_ROW_WRITE) && (7'(row_index) < 7'(MAP_ROWS));

	always_comb begin
		cos_c = sin_hd(11'(ang_q) + ANG_QUAD);
		sin_c = sin_hd(11'(ang_q));
		dc3_c = (DSTEP_W'(cos_c) <<< 1) + DSTEP_W'(cos_c);
		ds3_c = (DSTEP_W'(sin_c) <<< 1) + DSTEP_W'(sin_c);
		sxi = 15'(pos_x_q) + 15'(START_OFF_Q4);
		syi = 15'(pos_y_q) + 15'(START_OFF_Q4);
	end

	// cell of the current probe; a negative coordinate is off the map
	always_comb begin
		col_c = px_q[24:14] >> tile_shift_q;
		row_c = py_q[24:14] >> tile_shift_q;
		in_map_c = !px_q[PX_W-1] && !py_q[PX_W-1] &&
			(col_c < 11'(MAP_COLS_EFF)) && (row_c < 11'(MAP_ROWS));
	end

	assign wall = vld_s1 && in_map_s1 && rd_data[col_s1];
	assign finish = vld_s1 && (wall || (len_s1 == MAX_LEN));
	assign hgt_start = (state_q == S_MARCH) && finish;
	assign out_load = (state_q == S_HGT) && hstat.done && (!out_valid_q || !out_stall);

	tmrm_map_mem #(
		.ROWS (MAP_ROWS),
		.ROW_W(ROW_W)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(ROW_W'(row_index)),
		.wr_data(row_bits),
		.rd_addr(row_c[ROW_W-1:0]),
		.rd_data(rd_data)
	);

	tmrm_height u_height (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hgt_start),
		.len   (len_s1),
		.hh    (screen_h_q[SCR_W-1:1]),
		.stat  (hstat),
		.height(height)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_shift_q <= TILE_SHIFT_RST;
			screen_h_q <= SCREEN_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TILE_SHIFT:    tile_shift_q <= cfg_data[TSH_W-1:0];
				REG_SCREEN_HEIGHT: screen_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && command == CMD_CAST) begin
						pos_x_q <= pos_x;
						pos_y_q <= pos_y;
						ang_q <= angle;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					dc3_q <= dc3_c;
					ds3_q <= ds3_c;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					px_q <= $signed({1'b0, sxi, {SCALE_SH{1'b0}}}) + PX_W'(dc3_q);
					py_q <= $signed({1'b0, syi, {SCALE_SH{1'b0}}}) + PX_W'(ds3_q);
					len_q <= STEP_LEN;
					state_q <= S_MARCH;
				end
				S_MARCH: begin
					// issue the next probe while checking the previous one
					vld_s1 <= !finish && (len_q <= MAX_LEN);
					in_map_s1 <= in_map_c;
					col_s1 <= col_c[3:0];
					len_s1 <= len_q;
					px_q <= px_q + PX_W'(dc3_q);
					py_q <= py_q + PX_W'(ds3_q);
					len_q <= len_q + STEP_LEN;
					if (finish) begin
						fin_hit_q <= wall;
						fin_len_q <= len_s1;
						state_q <= S_HGT;
					end
				end
				S_HGT: begin
					// hold the result in the height unit until the output frees up
					if (out_load) begin
						ray_length_q <= fin_len_q;
						wall_hit_q <= fin_hit_q;
						half_height_q <= height;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign ray_length = ray_length_q;
	assign wall_hit = wall_hit_q;
	assign half_height = half_height_q;

	`TMRM_ASSERT(a_probe_len, vld_s1 |-> (len_s1 <= MAX_LEN))
	`TMRM_ASSERT_NEXT(a_finish_starts_hgt, (state_q == S_MARCH && finish), hstat.busy)
	`TMRM_ASSERT(a_idle_hgt_quiet, (state_q == S_IDLE) |-> !hstat.busy)
	`TMRM_ASSERT(a_out_len_nonzero, out_valid |-> (ray_length != '0))

endmodule
